// ----- rtl/tar_header_parser_assert.svh -----
// Assertion macros shared by the tar header parser modules.
`ifndef TAR_HEADER_PARSER_ASSERT_SVH
`define TAR_HEADER_PARSER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define TARHP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tar header parser: invariant violated");

// Antecedent implies consequent in the same cycle.
`define TARHP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tar header parser: implication violated");

// Antecedent implies consequent in the following cycle.
`define TARHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tar header parser: sequence violated");

`endif

// ----- rtl/tarhp_pkg.sv -----
// Types, constants and helpers shared by the tar header parser.
`default_nettype none

package tarhp_pkg;

    localparam int OFFSET_BITS_DEFAULT = 48;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [8:0] POS_MODE     = 9'd100;
    localparam logic [8:0] POS_OWNER    = 9'd108;
    localparam logic [8:0] POS_GROUP    = 9'd116;
    localparam logic [8:0] POS_SIZE     = 9'd124;
    localparam logic [8:0] POS_TIME     = 9'd136;
    localparam logic [8:0] POS_CHKSUM   = 9'd148;
    localparam logic [8:0] POS_TYPE     = 9'd156;
    localparam logic [8:0] POS_MAGIC    = 9'd257;
    localparam logic [8:0] POS_MAGIC_END = 9'd262;
    localparam logic [8:0] POS_LAST     = 9'd511;

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_SEVEN = 8'h37;
    localparam logic [7:0] ASCII_NUL   = 8'h00;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DEAD   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_DIGITS = 2'd1,
        SCAN_DONE   = 2'd2
    } octal_scan_t;

    typedef struct packed {
        logic [7:0]  entry_type;
        logic [20:0] file_mode;
        logic [20:0] owner_id;
        logic [20:0] group_id;
        logic [32:0] data_size;
        logic [32:0] modify_time;
        logic [47:0] data_offset;
        logic        checksum_ok;
        logic        gnu_format;
        logic        end_of_archive;
    } result_t;

    // Expected "ustar" character at each magic position.
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = ASCII_NUL;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tarhp_parser.sv -----
// Front end: walks header blocks byte by byte, accumulates fields, skips data.
`default_nettype none
`include "tar_header_parser_assert.svh"

module tarhp_parser #(
    parameter int OFFSET_BITS = tarhp_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [7:0]       in_byte,
    output tarhp_pkg::result_t    rec,
    output logic                  rec_valid
);
    import tarhp_pkg::*;

    localparam int OFS_W = (OFFSET_BITS < 48) ? OFFSET_BITS : 48;

    phase_t             phase_reg, phase_next;
    octal_scan_t        scan_reg, scan_next, scan_base;
    logic [8:0]         pos_reg, pos_next;
    logic [16:0]        sum_reg, sum_next, sum_base;
    logic [23:0]        stored_reg, stored_next;
    logic               magic_bad_reg, magic_bad_next;
    logic               magic_gnu_reg, magic_gnu_next;
    logic [7:0]         type_reg, type_next;
    logic [20:0]        mode_reg, mode_next;
    logic [20:0]        owner_reg, owner_next;
    logic [20:0]        group_reg, group_next;
    logic [32:0]        size_reg, size_next;
    logic [32:0]        time_reg, time_next;
    logic [32:0]        skip_reg, skip_next;
    logic [32:0]        size_m1;
    logic [OFFSET_BITS-1:0] ofs_reg, ofs_next;
    logic [8:0]         magic_idx;
    logic               field_start, in_octal, is_digit, is_space;
    logic               feed_hold, feed_digit;
    logic [7:0]         sum_add;

    always_comb
    begin
        phase_next     = phase_reg;
        scan_next      = scan_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        stored_next    = stored_reg;
        magic_bad_next = magic_bad_reg;
        magic_gnu_next = magic_gnu_reg;
        type_next      = type_reg;
        mode_next      = mode_reg;
        owner_next     = owner_reg;
        group_next     = group_reg;
        size_next      = size_reg;
        time_next      = time_reg;
        skip_next      = skip_reg;
        ofs_next       = ofs_reg;
        rec            = '0;
        rec_valid      = 1'b0;

        size_m1     = size_reg - 33'd1;
        magic_idx   = pos_reg - POS_MAGIC;
        field_start = (pos_reg == POS_MODE) || (pos_reg == POS_OWNER) ||
                      (pos_reg == POS_GROUP) || (pos_reg == POS_SIZE) ||
                      (pos_reg == POS_TIME) || (pos_reg == POS_CHKSUM);
        in_octal    = (pos_reg >= POS_MODE) && (pos_reg < POS_TYPE);
        scan_base   = field_start ? SCAN_IDLE : scan_reg;
        is_digit    = (in_byte >= ASCII_ZERO) && (in_byte <= ASCII_SEVEN);
        is_space    = (in_byte == ASCII_SPACE);
        feed_hold   = (scan_base == SCAN_IDLE) && is_space;
        feed_digit  = in_octal && !feed_hold && (scan_base != SCAN_DONE) && is_digit;
        sum_add     = ((pos_reg >= POS_CHKSUM) && (pos_reg < POS_TYPE)) ? ASCII_SPACE
                                                                         : in_byte;
        sum_base    = (pos_reg == '0) ? '0 : sum_reg;

        if (in_valid && (phase_reg != PH_DEAD))
        begin
            ofs_next = ofs_reg + 1'b1;
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (skip_reg == '0)
                        phase_next = PH_HEADER;
                    else
                        skip_next = skip_reg - 33'd1;
                end
                PH_HEADER:
                begin
                    if (pos_reg == '0)
                    begin
                        stored_next    = '0;
                        magic_bad_next = 1'b0;
                        magic_gnu_next = 1'b0;
                        type_next      = '0;
                        mode_next      = '0;
                        owner_next     = '0;
                        group_next     = '0;
                        size_next      = '0;
                        time_next      = '0;
                    end
                    sum_next = sum_base + 17'(sum_add);

                    if (in_octal)
                    begin
                        if (feed_hold)
                            scan_next = scan_base;
                        else if (feed_digit)
                            scan_next = SCAN_DIGITS;
                        else
                            scan_next = SCAN_DONE;
                    end
                    else
                        scan_next = scan_base;

                    if (feed_digit)
                    begin
                        if (pos_reg < POS_OWNER)
                            mode_next = {mode_reg[17:0], in_byte[2:0]};
                        else if (pos_reg < POS_GROUP)
                            owner_next = {owner_reg[17:0], in_byte[2:0]};
                        else if (pos_reg < POS_SIZE)
                            group_next = {group_reg[17:0], in_byte[2:0]};
                        else if (pos_reg < POS_TIME)
                            size_next = {size_reg[29:0], in_byte[2:0]};
                        else if (pos_reg < POS_CHKSUM)
                            time_next = {time_reg[29:0], in_byte[2:0]};
                        else
                            stored_next = {stored_reg[20:0], in_byte[2:0]};
                    end

                    if (pos_reg == POS_TYPE)
                        type_next = in_byte;

                    if ((pos_reg >= POS_MAGIC) && (pos_reg < POS_MAGIC_END))
                    begin
                        if (in_byte != magic_char(magic_idx[2:0]))
                            magic_bad_next = 1'b1;
                    end
                    else if (pos_reg == POS_MAGIC_END)
                    begin
                        if (is_space)
                            magic_gnu_next = 1'b1;
                        else if (in_byte != ASCII_NUL)
                            magic_bad_next = 1'b1;
                    end

                    if (pos_reg == POS_LAST)
                    begin
                        pos_next  = '0;
                        rec_valid = 1'b1;
                        if (magic_bad_reg)
                        begin
                            rec.end_of_archive = 1'b1;
                            phase_next         = PH_DEAD;
                        end
                        else
                        begin
                            rec.entry_type  = type_reg;
                            rec.file_mode   = mode_reg;
                            rec.owner_id    = owner_reg;
                            rec.group_id    = group_reg;
                            rec.data_size   = size_reg;
                            rec.modify_time = time_reg;
                            rec.data_offset = 48'(ofs_next[OFS_W-1:0]);
                            rec.checksum_ok = ({7'd0, sum_next} == stored_reg);
                            rec.gnu_format  = magic_gnu_reg;
                            // round the data up to whole blocks, minus one byte
                            if (size_reg != '0)
                            begin
                                skip_next  = {size_m1[32:9], 9'h1FF};
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    else
                        pos_next = pos_reg + 9'd1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            scan_reg      <= SCAN_IDLE;
            pos_reg       <= '0;
            sum_reg       <= '0;
            stored_reg    <= '0;
            magic_bad_reg <= 1'b0;
            magic_gnu_reg <= 1'b0;
            type_reg      <= '0;
            mode_reg      <= '0;
            owner_reg     <= '0;
            group_reg     <= '0;
            size_reg      <= '0;
            time_reg      <= '0;
            skip_reg      <= '0;
            ofs_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            scan_reg      <= scan_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            stored_reg    <= stored_next;
            magic_bad_reg <= magic_bad_next;
            magic_gnu_reg <= magic_gnu_next;
            type_reg      <= type_next;
            mode_reg      <= mode_next;
            owner_reg     <= owner_next;
            group_reg     <= group_next;
            size_reg      <= size_next;
            time_reg      <= time_next;
            skip_reg      <= skip_next;
            ofs_reg       <= ofs_next;
        end
    end

    `TARHP_ASSERT_IMPL(a_pos_only_in_header, clk, rst_n, phase_reg != PH_HEADER, pos_reg == '0)
    `TARHP_ASSERT_IMPL(a_rec_at_block_end, clk, rst_n, rec_valid, pos_reg == POS_LAST)
    `TARHP_ASSERT_NEXT(a_dead_sticks, clk, rst_n, phase_reg == PH_DEAD, phase_reg == PH_DEAD)

endmodule

`default_nettype wire

// ----- rtl/tarhp_result_queue.sv -----
// Back end: short result queue that presents the oldest header record.
`default_nettype none
`include "tar_header_parser_assert.svh"

module tarhp_result_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire tarhp_pkg::result_t  wr_data,
    input  wire logic                rd_en,
    output tarhp_pkg::result_t       rd_data,
    output logic                     q_empty,
    output logic                     q_full
);
    import tarhp_pkg::*;

    result_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                     do_wr, do_rd;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + QUEUE_CNT_W'(do_wr) - QUEUE_CNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            // pointers wrap naturally at the power-of-two depth
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `TARHP_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
    `TARHP_ASSERT_IMPL(a_no_write_when_full, clk, rst_n, q_full, !wr_en)
    `TARHP_ASSERT_NEXT(a_pop_drains, clk, rst_n, do_rd && !do_wr, count_reg == $past(count_reg) - 1'b1)

endmodule

`default_nettype wire

// ----- rtl/tar_header_parser.sv -----
// Top level of the streaming tar header parser.
//
// Input channel: one archive byte per beat on byte_value, taken when push is
// high and full is low. The stream is a sequence of 512-byte blocks; each
// header block yields one result, and the data blocks behind it are skipped.
// Result channel: the oldest record sits on the result ports while empty is
// low and leaves on a beat with pop high.
// Throughput: one byte per cycle while full is low; the parser never stalls
// on its own. Latency: a result enters the queue the cycle after the last
// (512th) byte of its header block is taken.
// The two-entry result queue decouples the sides: full rises only when two
// records wait unread, which stalls further bytes until the consumer pops.
// A header with bad magic yields a record with end_of_archive set and all
// other fields zero; every later byte is then taken and dropped.
// Reset clears the block position, accumulators, stream offset and queue;
// the first byte after reset starts a header block.
`default_nettype none

module tar_header_parser #(
    parameter int OFFSET_BITS = tarhp_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  byte_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       entry_type,
    output logic [20:0]      file_mode,
    output logic [20:0]      owner_id,
    output logic [20:0]      group_id,
    output logic [32:0]      data_size,
    output logic [32:0]      modify_time,
    output logic [47:0]      data_offset,
    output logic             checksum_ok,
    output logic             gnu_format,
    output logic             end_of_archive
);
    import tarhp_pkg::*;

    result_t rec, head;
    logic    rec_valid, accept;

    assign accept = push && !full;

    tarhp_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_byte   (byte_value),
        .rec       (rec),
        .rec_valid (rec_valid)
    );

    tarhp_result_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_data (rec),
        .rd_en   (pop),
        .rd_data (head),
        .q_empty (empty),
        .q_full  (full)
    );

    assign entry_type     = head.entry_type;
    assign file_mode      = head.file_mode;
    assign owner_id       = head.owner_id;
    assign group_id       = head.group_id;
    assign data_size      = head.data_size;
    assign modify_time    = head.modify_time;
    assign data_offset    = head.data_offset;
    assign checksum_ok    = head.checksum_ok;
    assign gnu_format     = head.gnu_format;
    assign end_of_archive = head.end_of_archive;

endmodule

`default_nettype wire
